// ===== rtl/ata_pkg.sv =====
// Shared types, constants and helpers for the affine transform accumulator.
// No dependencies.
package ata_pkg;

  localparam int unsigned FracBitsDef   = 16;
  localparam int unsigned AngleBitsDef  = 16;
  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned QueueDepth    = 2;
  localparam logic signed [33:0] CordicX0 = 34'sd652032874;

  typedef enum logic [2:0] {
    MODE_ROT_X = 3'd0,
    MODE_ROT_Y = 3'd1,
    MODE_ROT_Z = 3'd2,
    MODE_SHIFT = 3'd3,
    MODE_IDENT = 3'd4
  } mode_e;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [15:0] angle;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic signed [31:0] shift_z;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [31:0] col0;
    logic signed [31:0] col1;
    logic signed [31:0] col2;
    logic signed [31:0] col3;
    logic               last_row;
  } out_beat_t;

  // classified command handed from front to back
  typedef enum logic [1:0] {
    CMD_ROT   = 2'd0,
    CMD_SHIFT = 2'd1,
    CMD_IDENT = 2'd2,
    CMD_KEEP  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [1:0]         axis;
    logic signed [15:0] angle;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic signed [31:0] shift_z;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_MAC,
    ST_EMIT
  } state_e;

  function automatic logic [31:0] atan_turn32(input logic [4:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
        5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
        5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
        5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
        5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
        5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
        5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
        5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
        5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
        5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
        5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
        5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
        default: r = 32'h0;
      endcase
      return r;
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    if (v > 68'sh0_7FFF_FFFF)
      return 32'sh7FFF_FFFF;
    else if (v < -68'sh0_8000_0000)
      return 32'sh8000_0000;
    else
      return v[31:0];
  endfunction

endpackage

// ===== rtl/ata_front.sv =====
// Front end: accepts input beats, classifies the mode and queues commands.
// Depends on ata_pkg.
module ata_front
  import ata_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_beat_t in_data_i,
  output logic     cmd_valid_o,
  input  logic     cmd_take_i,
  output cmd_t     cmd_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  cmd_t            fifo_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  cmd_t            cmd_d;
  logic            push, pop;

  always_comb begin
    cmd_d.axis    = in_data_i.mode[1:0];
    cmd_d.angle   = in_data_i.angle;
    cmd_d.shift_x = in_data_i.shift_x;
    cmd_d.shift_y = in_data_i.shift_y;
    cmd_d.shift_z = in_data_i.shift_z;
    unique case (in_data_i.mode)
      MODE_ROT_X, MODE_ROT_Y, MODE_ROT_Z: cmd_d.cmd = CMD_ROT;
      MODE_SHIFT: cmd_d.cmd = CMD_SHIFT;
      MODE_IDENT: cmd_d.cmd = CMD_IDENT;
      default:    cmd_d.cmd = CMD_KEEP;
    endcase
  end

  assign in_stall_o  = (cnt_q == (PtrW+1)'(QueueDepth));
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_valid_o && cmd_take_i;
  assign cmd_o       = fifo_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_q] <= cmd_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

endmodule

// ===== rtl/ata_cordic.sv =====
// Iterative rotation-mode CORDIC giving quadrant-corrected cos and sin.
// Depends on ata_pkg.
module ata_cordic
  import ata_pkg::*;
#(
  parameter int unsigned FRAC_BITS    = FracBitsDef,
  parameter int unsigned ANGLE_BITS   = AngleBitsDef,
  parameter int unsigned CORDIC_STEPS = CordicStepsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [15:0]        angle_i,
  output logic               done_o,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);

  localparam int unsigned Drop = 32 - ANGLE_BITS;
  localparam int unsigned Rs   = 30 - FRAC_BITS;
  localparam int unsigned StW  = $clog2(CORDIC_STEPS + 1);

  logic signed [33:0]         x_q, y_q;
  logic signed [ANGLE_BITS:0] z_q;
  logic [1:0]                 quad_q;
  logic [StW-1:0]             step_q;
  logic                       busy_q;
  logic [ANGLE_BITS-1:0]      phase;
  logic [31:0]                a_full;
  logic signed [ANGLE_BITS:0] a_step;
  logic signed [33:0]         dx, dy;
  logic signed [31:0]         c_r, s_r;

  always_comb begin
    if (ANGLE_BITS >= 16)
      phase = ANGLE_BITS'({angle_i, 8'h00} >> (24 - ANGLE_BITS));
    else
      phase = ANGLE_BITS'(angle_i >> (16 - ANGLE_BITS));
    a_full = (atan_turn32(5'(step_q)) + (32'd1 << (Drop - 1))) >> Drop;
    a_step = (ANGLE_BITS+1)'(a_full);
    dx     = y_q >>> step_q;
    dy     = x_q >>> step_q;
  end

  function automatic logic signed [31:0] rnd(input logic signed [33:0] v);
    logic signed [35:0] t;
    begin
      if (Rs == 0) t = 36'(v);
      else t = (36'(v) + (36'sd1 <<< (Rs - 1))) >>> Rs;
      return sat32(68'(t));
    end
  endfunction

  always_comb begin
    c_r = rnd(x_q);
    s_r = rnd(y_q);
    case (quad_q)
      2'd0:    begin cos_o = c_r;  sin_o = s_r;  end
      2'd1:    begin cos_o = -s_r; sin_o = c_r;  end
      2'd2:    begin cos_o = -c_r; sin_o = -s_r; end
      default: begin cos_o = s_r;  sin_o = -c_r; end
    endcase
  end

  assign done_o = busy_q && (step_q == StW'(CORDIC_STEPS));

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= CordicX0;
      y_q    <= '0;
      z_q    <= (ANGLE_BITS+1)'({2'b00, phase[ANGLE_BITS-3:0]});
      quad_q <= phase[ANGLE_BITS-1:ANGLE_BITS-2];
    end else if (busy_q && !done_o) begin
      if (!z_q[ANGLE_BITS]) begin
        x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - a_step;
      end else begin
        x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + a_step;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      if (done_o) busy_q <= 1'b0;
      else step_q <= step_q + 1'b1;
    end
  end

endmodule

// ===== rtl/ata_back.sv =====
// Back end: builds the operand matrix, multiplies one product term per
// step with a shared multiplier, stores the matrix and emits four rows.
// Depends on ata_pkg and ata_cordic.
module ata_back
  import ata_pkg::*;
#(
  parameter int unsigned FRAC_BITS    = FracBitsDef,
  parameter int unsigned ANGLE_BITS   = AngleBitsDef,
  parameter int unsigned CORDIC_STEPS = CordicStepsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  output logic      cmd_take_o,
  input  cmd_t      cmd_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  localparam logic signed [31:0] One = 32'sd1 <<< FRAC_BITS;

  state_e             st_q, st_d;
  cmd_t               cmd_q;
  logic signed [31:0] m_q [16];
  logic signed [31:0] res_q [16];
  logic signed [31:0] c_q, s_q;
  logic [3:0]         el_q;   // output element index
  logic [1:0]         k_q;    // product term index
  logic [1:0]         row_q;
  logic signed [67:0] acc_q;
  logic               cor_start, cor_done;
  logic               start_q;
  logic signed [31:0] cor_c, cor_s;
  logic signed [31:0] a_op, b_op;
  logic signed [63:0] prod;
  logic signed [67:0] acc_n, rnd_v;

  // the CORDIC is started from the registered command
  ata_cordic #(
    .FRAC_BITS(FRAC_BITS), .ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i, .rst_ni,
    .start_i(start_q), .angle_i(cmd_q.angle),
    .done_o(cor_done), .cos_o(cor_c), .sin_o(cor_s)
  );

  // element (r, c) of the right-hand operand matrix
  function automatic logic signed [31:0] bval(
    input cmd_t cm, input logic signed [31:0] c, input logic signed [31:0] s,
    input logic [1:0] r, input logic [1:0] col);
    logic signed [31:0] v;
    begin
      v = (r == col) ? One : 32'sd0;
      if (cm.cmd == CMD_SHIFT && col == 2'd3) begin
        if (r == 2'd0) v = cm.shift_x;
        else if (r == 2'd1) v = cm.shift_y;
        else if (r == 2'd2) v = cm.shift_z;
      end else if (cm.cmd == CMD_ROT) begin
        case (cm.axis)
          2'd0: begin
            if ((r == 2'd1 && col == 2'd1) || (r == 2'd2 && col == 2'd2)) v = c;
            if (r == 2'd1 && col == 2'd2) v = -s;
            if (r == 2'd2 && col == 2'd1) v = s;
          end
          2'd1: begin
            if ((r == 2'd0 && col == 2'd0) || (r == 2'd2 && col == 2'd2)) v = c;
            if (r == 2'd0 && col == 2'd2) v = s;
            if (r == 2'd2 && col == 2'd0) v = -s;
          end
          default: begin
            if ((r == 2'd0 && col == 2'd0) || (r == 2'd1 && col == 2'd1)) v = c;
            if (r == 2'd0 && col == 2'd1) v = -s;
            if (r == 2'd1 && col == 2'd0) v = s;
          end
        endcase
      end
      return v;
    end
  endfunction

  always_comb begin
    a_op  = m_q[{el_q[3:2], k_q}];
    b_op  = bval(cmd_q, c_q, s_q, k_q, el_q[1:0]);
    prod  = a_op * b_op;
    acc_n = acc_q + 68'(prod);
    rnd_v = (acc_n + (68'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  end

  always_comb begin
    st_d       = st_q;
    cmd_take_o = 1'b0;
    cor_start  = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_take_o = 1'b1;
          if (cmd_i.cmd == CMD_ROT) begin
            cor_start = 1'b1;
            st_d      = ST_CORDIC;
          end else if (cmd_i.cmd == CMD_SHIFT) begin
            st_d = ST_MAC;
          end else begin
            st_d = ST_EMIT;
          end
        end
      end
      ST_CORDIC: if (cor_done) st_d = ST_MAC;
      ST_MAC:    if (k_q == 2'd3 && el_q == 4'd15) st_d = ST_EMIT;
      ST_EMIT:   if (!out_stall_i && row_q == 2'd3) st_d = ST_IDLE;
      default:   st_d = ST_IDLE;
    endcase
  end

  // cor_start is registered so the CORDIC sees the new angle in cmd_q: CORDIC loads on the cycle after take
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) start_q <= 1'b0;
    else start_q <= cor_start;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      el_q  <= '0;
      k_q   <= '0;
      row_q <= '0;
      for (int i = 0; i < 16; i++) m_q[i] <= (i % 5 == 0) ? One : 32'sd0;
    end else begin
      st_q <= st_d;
      if (st_q == ST_IDLE && cmd_valid_i && cmd_i.cmd == CMD_IDENT)
        for (int i = 0; i < 16; i++) m_q[i] <= (i % 5 == 0) ? One : 32'sd0;
      if (st_q == ST_MAC) begin
        k_q <= k_q + 1'b1;
        if (k_q == 2'd3) begin
          el_q <= el_q + 1'b1;
          if (el_q == 4'd15) begin
            for (int i = 0; i < 15; i++) m_q[i] <= res_q[i];
            m_q[15] <= sat32(rnd_v);
          end
        end
      end
      if (st_q == ST_EMIT && !out_stall_i) row_q <= row_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take_o) begin
      cmd_q <= cmd_i;
      c_q   <= One;
      s_q   <= '0;
      acc_q <= '0;
    end
    if (cor_done) begin
      c_q <= cor_c;
      s_q <= cor_s;
    end
    if (st_q == ST_MAC) begin
      if (k_q == 2'd3) begin
        res_q[el_q] <= sat32(rnd_v);
        acc_q       <= '0;
      end else begin
        acc_q <= acc_n;
      end
    end
  end

  assign out_valid_o          = (st_q == ST_EMIT);
  assign out_data_o.row_index = row_q;
  assign out_data_o.col0      = m_q[{row_q, 2'd0}];
  assign out_data_o.col1      = m_q[{row_q, 2'd1}];
  assign out_data_o.col2      = m_q[{row_q, 2'd2}];
  assign out_data_o.col3      = m_q[{row_q, 2'd3}];
  assign out_data_o.last_row  = (row_q == 2'd3);

endmodule

// ===== rtl/affine_transform_accumulator.sv =====
// Top level of the affine transform accumulator.
// Depends on ata_pkg, ata_front, ata_back (which holds ata_cordic).
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one command
//   beat: rotate about X, Y or Z by a binary angle, translate, or reload
//   identity. Output channel (out_valid_o / out_stall_i / out_data_o) then
//   carries four beats, rows 0..3 of the updated Q16.16 matrix, last_row set
//   on row 3. Modes 5..7 leave the matrix as is and still emit four rows.
//   On a rotation the back end takes the command, runs the CORDIC, then
//   multiply-accumulates (one 32x32 product per cycle, 4 per element) and
//   emits 4 row beats. Translation skips the CORDIC; identity and unused
//   modes go straight to the four row beats. The one shared multiplier
//   sets the throughput. A two-entry command queue between front and back
//   accepts new beats while the back end is busy or stalled by the receiver.
//   Reset: matrix goes to identity, queue empties, no beats pending.
//   Receiver stall simply holds the current row beat.
module affine_transform_accumulator
  import ata_pkg::*;
#(
  parameter int unsigned FRAC_BITS    = FracBitsDef,
  parameter int unsigned ANGLE_BITS   = AngleBitsDef,
  parameter int unsigned CORDIC_STEPS = CordicStepsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  logic cmd_valid, cmd_take;
  cmd_t cmd;

  ata_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .in_data_i,
    .cmd_valid_o(cmd_valid), .cmd_take_i(cmd_take), .cmd_o(cmd)
  );

  ata_back #(
    .FRAC_BITS(FRAC_BITS), .ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)
  ) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_take_o(cmd_take), .cmd_i(cmd),
    .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule

// ===== rtl/ata_checker.sv =====
// Port-level checker for the affine transform accumulator, bound to the top.
// Depends on ata_pkg.
module ata_checker
  import ata_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_beat_t out_data_o
);

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last_row == (out_data_o.row_index == 2'd3)))
    else $error("last_row mismatch");

  a_row_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_data_o.row_index != 2'd3) |=>
      (out_valid_o && out_data_o.row_index == $past(out_data_o.row_index) + 2'd1))
    else $error("rows not consecutive");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled beat changed");

  a_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (out_data_o.row_index == 2'd0))
    else $error("matrix does not start at row 0");

endmodule

bind affine_transform_accumulator ata_checker u_ata_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .out_data_o
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for affine_transform_accumulator: drives command beats,
// predicts each matrix row in Q16.16 and compares every output beat. Depends on ata_pkg.
module testbench;
  import ata_pkg::*;

  localparam int FracBits    = 16;
  localparam int CordicSteps = 16;
  localparam int RandomBeats = 350;
  localparam int MaxErrShown = 10;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_data;

  affine_transform_accumulator i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // predictor state: the accumulated matrix, row major
  logic signed [31:0] matrix_q [16];

  in_beat_t  cmd_queue [$];   // commands waiting for the driver
  out_beat_t row_queue [$];   // predicted rows, oldest first
  int        mismatches;
  bit        stim_done;
  bit        drain_hold;      // sender pause until all rows are back
  int        hold_off_req;    // requested length of the long receiver hold-off
  int        hold_off_cycles; // long receiver hold-off, counted down
  bit        in_acc;          // input beat accepted at the last rising edge

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [63:0] floor_sh(input logic signed [63:0] v, input int s);
    return v >>> s;
  endfunction

  function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] atan_entry(input int i);
    logic [31:0] t [24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
    return t[i];
  endfunction

  // rotation-mode CORDIC at 16 angle bits, then quadrant fold
  task automatic sine_cosine(input logic [15:0] phase,
                             output logic signed [31:0] cos_v,
                             output logic signed [31:0] sin_v);
    logic signed [63:0] x, y, z, a, dx, dy;
    logic signed [31:0] c, s;
    logic [1:0] quad;
    x = 64'sd652032874;
    y = 0;
    quad = phase[15:14];
    z = {50'd0, phase[13:0]};
    for (int i = 0; i < CordicSteps; i++) begin
      a = (atan_entry(i) + 64'd32768) >> 16;
      dx = floor_sh(y, i);
      dy = floor_sh(x, i);
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - a;
      end else begin
        x = x + dx; y = y - dy; z = z + a;
      end
    end
    c = clip32(floor_sh(x + (64'sd1 << (29 - FracBits)), 30 - FracBits));
    s = clip32(floor_sh(y + (64'sd1 << (29 - FracBits)), 30 - FracBits));
    case (quad)
      2'd0: begin cos_v = c;  sin_v = s;  end
      2'd1: begin cos_v = -s; sin_v = c;  end
      2'd2: begin cos_v = -c; sin_v = -s; end
      default: begin cos_v = s; sin_v = -c; end
    endcase
  endtask

  task automatic load_identity(output logic signed [31:0] m [16]);
    for (int k = 0; k < 16; k++) m[k] = (k % 5 == 0) ? 32'sd65536 : 32'sd0;
  endtask

  // apply one command to the matrix and queue its four rows
  task automatic apply_command(input in_beat_t cmd);
    logic signed [31:0] op [16];
    logic signed [31:0] prod [16];
    logic signed [31:0] c, s;
    logic signed [63:0] p, hi, lo;
    out_beat_t row;
    load_identity(op);
    if (cmd.mode inside {MODE_ROT_X, MODE_ROT_Y, MODE_ROT_Z}) begin
      sine_cosine(cmd.angle, c, s);
      case (cmd.mode)
        MODE_ROT_X: begin op[5] = c; op[6] = -s; op[9] = s; op[10] = c; end
        MODE_ROT_Y: begin op[0] = c; op[2] = s; op[8] = -s; op[10] = c; end
        default:    begin op[0] = c; op[1] = -s; op[4] = s; op[5] = c; end
      endcase
    end else if (cmd.mode == MODE_SHIFT) begin
      op[3] = cmd.shift_x; op[7] = cmd.shift_y; op[11] = cmd.shift_z;
    end
    if (cmd.mode <= MODE_SHIFT) begin
      for (int r = 0; r < 4; r++)
        for (int col = 0; col < 4; col++) begin
          hi = 0; lo = 0;
          for (int k = 0; k < 4; k++) begin
            p = 64'(matrix_q[r*4+k]) * 64'(op[k*4+col]);
            hi += floor_sh(p, 2);
            lo += {62'd0, p[1:0]};
          end
          hi += 64'sd1 << (FracBits - 3);
          hi += lo >>> 2;
          prod[r*4+col] = clip32(floor_sh(hi, FracBits - 2));
        end
      matrix_q = prod;
    end else if (cmd.mode == MODE_IDENT) begin
      load_identity(matrix_q);
    end
    for (int r = 0; r < 4; r++) begin
      row.row_index = r[1:0];
      row.col0 = matrix_q[r*4];
      row.col1 = matrix_q[r*4+1];
      row.col2 = matrix_q[r*4+2];
      row.col3 = matrix_q[r*4+3];
      row.last_row = (r == 3);
      row_queue.push_back(row);
    end
  endtask

  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic in_beat_t random_cmd(input logic [2:0] mode);
    in_beat_t b;
    b.mode = mode;
    b.angle = 16'($urandom);
    b.shift_x = $urandom;
    b.shift_y = $urandom;
    b.shift_z = $urandom;
    // mostly modest shifts so the matrix does not pin at saturation
    if ($urandom_range(0, 3) != 0) begin
      b.shift_x = $signed(b.shift_x) >>> 8;
      b.shift_y = $signed(b.shift_y) >>> 8;
      b.shift_z = $signed(b.shift_z) >>> 8;
    end
    return b;
  endfunction

  // acceptance is judged at the rising edge, where the handshake happens
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) in_acc <= 1'b0;
    else in_acc <= in_valid && !in_stall;
  end

  // driver: a beat leaves the queue only when accepted
  int send_gap;
  always @(negedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      send_gap <= 0;
    end else if (!in_valid || in_acc) begin
      // previous beat, if any, was accepted at the last rising edge
      if (in_valid) begin
        apply_command(cmd_queue.pop_front());
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (cmd_queue.size() > 0 &&
                   !(drain_hold && (row_queue.size() > 0 || in_valid))) begin
        in_valid <= 1'b1;
        in_data  <= cmd_queue[0];
        send_gap <= gap_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, counted in cycles
  always @(negedge clk or negedge rst_n) begin
    if (!rst_n) begin
      hold_off_cycles <= 0;
    end else if (hold_off_req > 0) begin
      hold_off_cycles <= hold_off_req;
      hold_off_req    <= 0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
    end
  end

  // receiver stall: random gaps plus the long hold-off
  int stall_left;
  always @(negedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (hold_off_cycles > 0) begin
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else begin
      out_stall  <= 1'b0;
      stall_left <= gap_len();
    end
  end

  // monitor
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (row_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxErrShown)
          $display("unexpected row beat %p", out_data);
      end else begin
        want = row_queue.pop_front();
        if (want !== out_data) begin
          mismatches++;
          if (mismatches <= MaxErrShown)
            $display("row mismatch: expected %p got %p", want, out_data);
        end
      end
    end
  end

  initial begin
    in_beat_t b;
    int signed angles [12];
    angles = '{0, 1, -1, 16384, -16384, -32768, 32767, 8192,
               16383, 16385, -8192, 4096};
    mismatches = 0;
    stim_done = 0;
    drain_hold = 0;
    hold_off_req = 0;
    load_identity(matrix_q);
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: every mode, angle corners, shift extremes, unused modes
    for (int i = 0; i < 12; i++) begin
      b = random_cmd(3'(i % 3));
      b.angle = 16'(angles[i]);
      cmd_queue.push_back(b);
    end
    b = random_cmd(MODE_SHIFT);
    b.shift_x = 32'sh7FFF_FFFF; b.shift_y = 32'sh8000_0000; b.shift_z = 0;
    cmd_queue.push_back(b);
    b.shift_x = 32'sh8000_0000; b.shift_y = 32'sh7FFF_FFFF; b.shift_z = -1;
    cmd_queue.push_back(b);
    cmd_queue.push_back(random_cmd(3'd5));
    cmd_queue.push_back(random_cmd(MODE_IDENT));
    cmd_queue.push_back(random_cmd(3'd6));
    cmd_queue.push_back(random_cmd(3'd7));
    b = '1;
    b.mode = MODE_SHIFT;
    cmd_queue.push_back(b);
    cmd_queue.push_back(random_cmd(MODE_IDENT));
    wait (cmd_queue.size() == 0 && row_queue.size() == 0);

    // long receiver hold-off while commands keep coming: input must back up
    hold_off_req = 600;
    for (int i = 0; i < 8; i++) cmd_queue.push_back(random_cmd(3'($urandom_range(0, 3))));
    wait (hold_off_cycles > 0);
    wait (cmd_queue.size() == 0 && hold_off_cycles == 0);

    // random part; identity now and then keeps the matrix from running away
    for (int i = 0; i < RandomBeats; i++) begin
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) b = random_cmd(3'($urandom_range(0, 2)));
      else if (roll < 85) b = random_cmd(MODE_SHIFT);
      else if (roll < 93) b = random_cmd(MODE_IDENT);
      else b = random_cmd(3'($urandom_range(5, 7)));
      cmd_queue.push_back(b);
      if (i == RandomBeats / 2) begin
        // sender pause: nothing more goes out until every row is back
        wait (cmd_queue.size() == 0);
        drain_hold = 1;
        wait (row_queue.size() == 0 && !in_valid);
        drain_hold = 0;
      end
    end
    wait (cmd_queue.size() == 0 && row_queue.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && row_queue.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
